// ----- src/utd_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package utd_pkg;

	// Byte range for the one-byte form and lead byte ranges for the two, three and four byte forms.
	localparam logic [7:0] AsciiMin   = 8'h01;
	localparam logic [7:0] AsciiMax   = 8'h7F;
	localparam logic [7:0] Lead2Min   = 8'hC2;
	localparam logic [7:0] Lead2Max   = 8'hDF;
	localparam logic [7:0] Lead3Min   = 8'hE0;
	localparam logic [7:0] Lead3Max   = 8'hEF;
	localparam logic [7:0] Lead4Min   = 8'hF0;
	localparam logic [7:0] Lead4Max   = 8'hF4;

	// Lead bytes that narrow the range of the second byte.
	localparam logic [7:0] LeadE0     = 8'hE0;
	localparam logic [7:0] LeadED     = 8'hED;
	localparam logic [7:0] LeadF0     = 8'hF0;
	localparam logic [7:0] LeadF4     = 8'hF4;
	localparam logic [7:0] AfterE0Min = 8'hA0;
	localparam logic [7:0] AfterEDMax = 8'h9F;
	localparam logic [7:0] AfterF0Min = 8'h90;
	localparam logic [7:0] AfterF4Max = 8'h8F;

	localparam logic [1:0] ContTag    = 2'b10;

	// Code point limits and surrogate bases.
	localparam logic [20:0] BmpMax      = 21'h00FFFF;
	localparam logic [20:0] SupplBase   = 21'h010000;
	localparam logic [15:0] HighSurBase = 16'hD800;
	localparam logic [15:0] LowSurBase  = 16'hDC00;

	// Result buffer depth; one input byte yields at most two results.
	localparam int ResDepth = 4;
	localparam int ResPtrW  = $clog2(ResDepth);
	localparam int ResCntW  = $clog2(ResDepth + 1);

	typedef struct packed {
		logic [20:0] code_accum;
		logic [1:0]  bytes_left;
		logic [7:0]  lead_byte;
		logic        second_pending;
		logic        discarding;
	} dec_state_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        error;
		logic        last;
	} result_t;

endpackage

// ----- src/utd_if.sv -----
// Handshake interfaces for the byte channel and the code unit channel.
`timescale 1ns / 1ps

interface utd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
	modport mon (input valid, input byte_value, input last_byte, input ready);
endinterface

interface utd_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        error;
	logic        last;

	modport source (output valid, output code_unit, output error, output last, input ready);
	modport sink (input valid, input code_unit, input error, input last, output ready);
	modport mon (input valid, input code_unit, input error, input last, input ready);
endinterface

// ----- src/utd_decode.sv -----
// Single-step UTF-8 decode logic: next state and up to two results per byte.
`timescale 1ns / 1ps

module utd_decode (
	input  utd_pkg::dec_state_t cur,
	input  logic [7:0]          byte_value,
	input  logic                last_byte,
	output utd_pkg::dec_state_t nxt,
	output logic [1:0]          res_cnt,
	output utd_pkg::result_t    res0,
	output utd_pkg::result_t    res1
);
	import utd_pkg::*;

	logic        bad;
	logic        done;
	logic        range_bad;
	logic [20:0] shifted;
	logic [20:0] cp;
	logic [20:0] adj;

	assign shifted = {cur.code_accum[14:0], byte_value[5:0]};

	assign range_bad = (cur.lead_byte == LeadE0 && byte_value < AfterE0Min) ||
	                   (cur.lead_byte == LeadED && byte_value > AfterEDMax) ||
	                   (cur.lead_byte == LeadF0 && byte_value < AfterF0Min) ||
	                   (cur.lead_byte == LeadF4 && byte_value > AfterF4Max);

	always_comb begin
		nxt     = cur;
		bad     = 1'b0;
		done    = 1'b0;
		res_cnt = 2'd0;
		res0    = '0;
		res1    = '0;
		cp      = '0;
		adj     = '0;

		if (!cur.discarding) begin
			if (cur.bytes_left == 2'd0) begin
				if (byte_value >= AsciiMin && byte_value <= AsciiMax) begin
					nxt.code_accum = {13'd0, byte_value};
					done           = 1'b1;
				end else if (byte_value >= Lead2Min && byte_value <= Lead2Max) begin
					nxt.code_accum     = {16'd0, byte_value[4:0]};
					nxt.bytes_left     = 2'd1;
					nxt.lead_byte      = byte_value;
					nxt.second_pending = 1'b0;
				end else if (byte_value >= Lead3Min && byte_value <= Lead3Max) begin
					nxt.code_accum     = {17'd0, byte_value[3:0]};
					nxt.bytes_left     = 2'd2;
					nxt.lead_byte      = byte_value;
					nxt.second_pending = 1'b1;
				end else if (byte_value >= Lead4Min && byte_value <= Lead4Max) begin
					nxt.code_accum     = {18'd0, byte_value[2:0]};
					nxt.bytes_left     = 2'd3;
					nxt.lead_byte      = byte_value;
					nxt.second_pending = 1'b1;
				end else begin
					bad = 1'b1;
				end
			end else begin
				if (byte_value[7:6] != ContTag) begin
					bad = 1'b1;
				end else if (cur.second_pending && range_bad) begin
					bad = 1'b1;
				end else begin
					nxt.second_pending = 1'b0;
					nxt.code_accum     = shifted;
					nxt.bytes_left     = cur.bytes_left - 2'd1;
					done               = (cur.bytes_left == 2'd1);
				end
			end
			// A string that ends inside a sequence is malformed.
			if (!bad && last_byte && !done) begin
				bad = 1'b1;
			end
			if (bad) begin
				nxt.discarding = 1'b1;
			end
		end

		if (nxt.discarding) begin
			if (last_byte) begin
				res_cnt = 2'd1;
				res0    = '{code_unit: 16'd0, error: 1'b1, last: 1'b1};
				nxt     = '0;
			end
		end else begin
			if (done) begin
				cp = nxt.code_accum;
				if (cp <= BmpMax) begin
					res_cnt = 2'd1;
					res0    = '{code_unit: cp[15:0], error: 1'b0, last: last_byte};
				end else begin
					adj     = cp - SupplBase;
					res_cnt = 2'd2;
					res0    = '{code_unit: HighSurBase + {6'd0, adj[19:10]},
					            error: 1'b0, last: 1'b0};
					res1    = '{code_unit: LowSurBase + {6'd0, adj[9:0]},
					            error: 1'b0, last: last_byte};
				end
				nxt.code_accum     = '0;
				nxt.lead_byte      = '0;
				nxt.second_pending = 1'b0;
				nxt.bytes_left     = 2'd0;
			end
			if (last_byte) begin
				nxt = '0;
			end
		end
	end

endmodule

// ----- src/utd_res_fifo.sv -----
// Small result queue that takes up to two results a cycle and hands out one.
`timescale 1ns / 1ps

module utd_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_cnt,
	input  utd_pkg::result_t   push0,
	input  utd_pkg::result_t   push1,
	output logic               room2,
	utd_unit_if.source         units
);
	import utd_pkg::*;

	result_t              mem [ResDepth];
	logic [ResPtrW-1:0]   wr_q;
	logic [ResPtrW-1:0]   rd_q;
	logic [ResCntW-1:0]   cnt_q;
	logic [ResPtrW-1:0]   wr_next;
	logic                 pop;

	assign wr_next = wr_q + ResPtrW'(1);
	assign pop     = units.valid && units.ready;
	assign room2   = (cnt_q <= ResCntW'(ResDepth - 2));

	assign units.valid     = (cnt_q != '0);
	assign units.code_unit = mem[rd_q].code_unit;
	assign units.error     = mem[rd_q].error;
	assign units.last      = mem[rd_q].last;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_next] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + ResPtrW'(push_cnt);
			if (pop) begin
				rd_q <= rd_q + ResPtrW'(1);
			end
			cnt_q <= cnt_q + ResCntW'(push_cnt) - ResCntW'(pop);
		end
	end

endmodule

// ----- src/utf8_to_utf16_decoder.sv -----
// Top level of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

// Usage:
// The bytes channel takes a string one UTF-8 byte per request, with last_byte set on the
// string's final byte. The units channel returns UTF-16 code units, one per request; a
// code point above U+FFFF comes out as a high then a low surrogate in two requests.
// Each string ends with exactly one request that has last set. If the string was
// malformed (NUL, overlong form, surrogate, value above U+10FFFF, bad lead or
// continuation byte, or a sequence cut short), nothing more is sent for it after the
// fault, and its final byte yields one request with error set and code_unit zero. The
// consumer then drops the units it already took for that string.
// An accepted byte is held in the input stage, then decoded and written into the result
// queue, from which its first unit is offered. Throughput is one byte per cycle while
// the queue can take a pair. A surrogate pair comes from a four-byte sequence, so
// even then the output has two units to send per four bytes and never sets the rate
// while the receiver keeps ready high. A four-entry result queue sits behind the
// decoder, so bytes keep flowing while a finished unit waits to be taken. When the
// receiver stalls the queue fills, and bytes.ready drops while a byte is staged and
// fewer than two entries are free. Reset clears the decoder state, the input stage and
// the queue; no request is offered until the first byte arrives.

module utf8_to_utf16_decoder (
	input  logic       clk,
	input  logic       arst_n,
	utd_byte_if.sink   bytes,
	utd_unit_if.source units
);
	import utd_pkg::*;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Decoder state carried between bytes of a string.
	dec_state_t state_q;
	dec_state_t state_next;

	logic [1:0] res_cnt;
	result_t    res0;
	result_t    res1;
	logic       room2;
	logic       advance;

	// The staged byte moves into the decoder when the queue can take a pair.
	assign advance     = valid_s1 && room2;
	assign bytes.ready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.byte_value;
			last_s1 <= bytes.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	utd_decode u_decode (
		.cur        (state_q),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.nxt        (state_next),
		.res_cnt    (res_cnt),
		.res0       (res0),
		.res1       (res1)
	);

	utd_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (advance ? res_cnt : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.room2    (room2),
		.units    (units)
	);

endmodule

// ----- src/utd_checker.sv -----
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
`timescale 1ns / 1ps

module utd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        bytes_ready,
	input logic        units_valid,
	input logic        units_ready,
	input logic [15:0] units_code_unit,
	input logic        units_error,
	input logic        units_last
);

	// A stalled request keeps its content.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		units_valid && !units_ready |=> units_valid && $stable(units_code_unit) &&
		$stable(units_error) && $stable(units_last))
		else $error("units request changed while stalled");

	// An error request closes the string and carries no code unit.
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		units_valid && units_error |-> units_last && units_code_unit == 16'd0)
		else $error("error request without last or with nonzero unit");

	// A high surrogate is never the final unit of a string.
	a_high_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		units_valid && !units_error && units_code_unit[15:10] == 6'b110110 |-> !units_last)
		else $error("high surrogate marked as last");

	// NUL is rejected, so a good unit is never zero.
	a_no_nul: assert property (@(posedge clk) disable iff (!arst_n)
		units_valid && !units_error |-> units_code_unit != 16'd0)
		else $error("zero code unit without error");

	// With the result queue empty there is always room for a byte.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!units_valid |-> bytes_ready)
		else $error("bytes channel stalled with an empty queue");

endmodule

bind utf8_to_utf16_decoder utd_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.bytes_ready     (bytes.ready),
	.units_valid     (units.valid),
	.units_ready     (units.ready),
	.units_code_unit (units.code_unit),
	.units_error     (units.error),
	.units_last      (units.last)
);

// ----- sim/utf8_to_utf16_decoder_test.sv -----
// Self-checking testbench for the UTF-8 to UTF-16 decoder, with its own decoding model.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_test;
	import utd_pkg::*;

	// Each cycle's chance of idling, in percent, for the idling phases that follow the
	// directed part: free flow, sender gaps, receiver stalls, then both together.
	localparam int PhaseCount = 4;
	localparam int SendIdlePct [PhaseCount] = '{0, 54, 0, 38};
	localparam int RecvStallPct [PhaseCount] = '{0, 0, 54, 38};

	// Bytes per phase that the decoder actually works on. Bytes that follow a fault in
	// the same string are swallowed by the block and are not counted here.
	localparam int PhaseBytes = 400;

	// The long receiver hold-off is far longer than the four-entry result queue can
	// cover, so the byte channel has to back up behind it.
	localparam int HoldCycles = 300;

	// A unit passes through the input stage and the result queue before it can be taken;
	// the drain allows for that with a wide margin.
	localparam int DrainCycles = 16;

	// The watchdog fires after this many cycles in which neither channel moves a
	// request. The slowest legal gap is the hold-off above; random stalls are short.
	localparam int StallLimit = 4000;

	// How a row of the directed table is checked: by the decoding model, or against a
	// result typed into the row (nothing at all, or exactly one request).
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NONE,
		ROW_UNIT
	} row_kind_t;

	typedef struct packed {
		logic [7:0]  value;
		logic        fin;
		row_kind_t   kind;
		logic [15:0] code_unit;
		logic        error;
		logic        last;
	} stim_row_t;

	// Directed strings: plain ASCII up to 7F, a NUL, a bad lead byte followed by a byte that
	// must be swallowed, the U+0080 and U+10FFFF extremes, all four second-byte range
	// limits, a bad continuation byte, a string cut short, and U+FFFF.
	localparam int DirectedCount = 26;
	localparam stim_row_t DirectedRows [DirectedCount] = '{
		'{8'h41, 1'b0, ROW_UNIT,    16'h0041, 1'b0, 1'b0},
		'{8'h7F, 1'b1, ROW_UNIT,    16'h007F, 1'b0, 1'b1},
		'{8'h00, 1'b1, ROW_UNIT,    16'h0000, 1'b1, 1'b1},
		'{8'hFF, 1'b0, ROW_NONE,    16'h0000, 1'b0, 1'b0},
		'{8'h41, 1'b1, ROW_UNIT,    16'h0000, 1'b1, 1'b1},
		'{8'hC2, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'h80, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'hF4, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'h8F, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'hBF, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'hBF, 1'b1, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'hE0, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'h9F, 1'b1, ROW_UNIT,    16'h0000, 1'b1, 1'b1},
		'{8'hED, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'hA0, 1'b1, ROW_UNIT,    16'h0000, 1'b1, 1'b1},
		'{8'hF0, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'h8F, 1'b1, ROW_UNIT,    16'h0000, 1'b1, 1'b1},
		'{8'hF4, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'h90, 1'b1, ROW_UNIT,    16'h0000, 1'b1, 1'b1},
		'{8'hC2, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'h41, 1'b1, ROW_UNIT,    16'h0000, 1'b1, 1'b1},
		'{8'hE0, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'hA0, 1'b1, ROW_UNIT,    16'h0000, 1'b1, 1'b1},
		'{8'hEF, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'hBF, 1'b0, ROW_PREDICT, 16'h0000, 1'b0, 1'b0},
		'{8'hBF, 1'b1, ROW_PREDICT, 16'h0000, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;

	utd_byte_if byte_ch ();
	utd_unit_if unit_ch ();

	utf8_to_utf16_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch)
	);

	// Decoder state as the model keeps it.
	logic [20:0] dec_accum;
	logic [1:0]  dec_left;
	logic [7:0]  dec_lead;
	logic        dec_second;
	logic        dec_discard;

	// Code units still owed by the block, oldest first.
	result_t pending_units [$];

	// Bytes of the string being built for the random part.
	logic [7:0] text_bytes [$];

	int send_idle_pct;
	int recv_stall_pct;
	int live_bytes;
	int error_count;
	logic hold_request;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Clears the decoding state, as reset and the end of every string do.
	function automatic void clear_decoder();
		dec_accum = '0;
		dec_left = '0;
		dec_lead = '0;
		dec_second = 1'b0;
		dec_discard = 1'b0;
	endfunction

	// Adds a unit at the tail of the list of units owed.
	function automatic void owe_unit(input result_t unit);
		pending_units.insert(pending_units.size(), unit);
	endfunction

	// Adds a byte at the end of the string being built.
	function automatic void add_text_byte(input logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endfunction

	// Steps the decoding model by one byte. It returns how many requests the byte
	// causes (zero, one or a surrogate pair) and hands them back in order.
	function automatic int decode_byte(input logic [7:0] b, input logic fin,
			output result_t first, output result_t second);
		logic bad;
		logic done;
		logic [20:0] offset;

		bad = 1'b0;
		done = 1'b0;
		first = '0;
		second = '0;
		if (!dec_discard) begin
			if (dec_left == 2'd0) begin
				if (b >= AsciiMin && b <= AsciiMax) begin
					dec_accum = {13'd0, b};
					done = 1'b1;
				end else if (b >= Lead2Min && b <= Lead2Max) begin
					dec_accum = {16'd0, b[4:0]};
					dec_left = 2'd1;
					dec_lead = b;
					dec_second = 1'b0;
				end else if (b >= Lead3Min && b <= Lead3Max) begin
					dec_accum = {17'd0, b[3:0]};
					dec_left = 2'd2;
					dec_lead = b;
					dec_second = 1'b1;
				end else if (b >= Lead4Min && b <= Lead4Max) begin
					dec_accum = {18'd0, b[2:0]};
					dec_left = 2'd3;
					dec_lead = b;
					dec_second = 1'b1;
				end else begin
					bad = 1'b1;
				end
			end else begin
				if (b[7:6] != ContTag) begin
					bad = 1'b1;
				end else if (dec_second && ((dec_lead == LeadE0 && b < AfterE0Min) ||
						(dec_lead == LeadED && b > AfterEDMax) ||
						(dec_lead == LeadF0 && b < AfterF0Min) ||
						(dec_lead == LeadF4 && b > AfterF4Max))) begin
					bad = 1'b1;
				end else begin
					dec_second = 1'b0;
					dec_accum = {dec_accum[14:0], b[5:0]};
					dec_left = dec_left - 2'd1;
					done = (dec_left == 2'd0);
				end
			end
			// A final byte that leaves a sequence open is a fault too.
			if (!bad && fin && !done)
				bad = 1'b1;
			if (bad)
				dec_discard = 1'b1;
		end

		if (dec_discard) begin
			if (!fin)
				return 0;
			first = '{code_unit: 16'h0000, error: 1'b1, last: 1'b1};
			clear_decoder();
			return 1;
		end

		if (!done) begin
			if (fin)
				clear_decoder();
			return 0;
		end

		if (dec_accum <= BmpMax) begin
			first = '{code_unit: dec_accum[15:0], error: 1'b0, last: fin};
			clear_decoder();
			return 1;
		end
		offset = dec_accum - SupplBase;
		first = '{code_unit: HighSurBase + {6'd0, offset[19:10]}, error: 1'b0, last: 1'b0};
		second = '{code_unit: LowSurBase + {6'd0, offset[9:0]}, error: 1'b0, last: fin};
		clear_decoder();
		return 2;
	endfunction

	// Offers one byte, idling before it at the phase's rate, and waits until it is
	// taken. Prediction happens at the edge of acceptance, so the units a byte causes are
	// owed before the block can offer them. Typed rows still step the model so that its
	// state keeps up, but the typed result stands in for the predicted one.
	task automatic send_byte(input logic [7:0] b, input logic fin, input row_kind_t kind,
			input result_t typed);
		result_t first;
		result_t second;
		int count;

		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.byte_value <= b;
		byte_ch.last_byte <= fin;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);

		if (!dec_discard)
			live_bytes++;
		count = decode_byte(b, fin, first, second);
		case (kind)
			ROW_PREDICT: begin
				if (count > 0)
					owe_unit(first);
				if (count > 1)
					owe_unit(second);
			end
			ROW_UNIT: begin
				owe_unit(typed);
			end
			default: begin
			end
		endcase
	endtask

	// Stops offering bytes and waits until the block has handed over every unit that
	// is owed, then realigns to a clock edge before anything is driven again.
	task automatic pause_until_drained();
		byte_ch.valid <= 1'b0;
		wait (pending_units.size() == 0);
		@(posedge clk);
	endtask

	// A code point from one of the four encoded lengths, never a surrogate.
	function automatic int random_code_point();
		int cp;

		case ($urandom_range(3))
			0: cp = $urandom_range(32'h7F, 32'h01);
			1: cp = $urandom_range(32'h7FF, 32'h80);
			2: begin
				cp = $urandom_range(32'hFFFF, 32'h800);
				if (cp >= 32'hD800 && cp <= 32'hDFFF)
					cp = cp - 32'h1000;
			end
			default: cp = $urandom_range(32'h10FFFF, 32'h10000);
		endcase
		return cp;
	endfunction

	// Appends the shortest UTF-8 form of a code point to the string being built.
	task automatic append_code_point(input int cp);
		logic [20:0] bits;

		bits = cp[20:0];
		if (cp < 32'h80) begin
			add_text_byte(bits[7:0]);
		end else if (cp < 32'h800) begin
			add_text_byte({3'b110, bits[10:6]});
			add_text_byte({2'b10, bits[5:0]});
		end else if (cp < 32'h10000) begin
			add_text_byte({4'b1110, bits[15:12]});
			add_text_byte({2'b10, bits[11:6]});
			add_text_byte({2'b10, bits[5:0]});
		end else begin
			add_text_byte({5'b11110, bits[20:18]});
			add_text_byte({2'b10, bits[17:12]});
			add_text_byte({2'b10, bits[11:6]});
			add_text_byte({2'b10, bits[5:0]});
		end
	endtask

	// Builds one random string. Most strings are well formed so that the multi-byte
	// paths get exercised; some carry a replaced byte (half the time a continuation
	// byte, which hits the second-byte range limits when it lands after a lead), some
	// are cut short, some get a stray byte inserted, and a few are pure noise.
	task automatic build_text();
		int pick;
		int count;
		int pos;

		text_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 6) begin
			count = $urandom_range(4, 1);
			repeat (count)
				add_text_byte(8'($urandom_range(255)));
			return;
		end

		count = $urandom_range(6, 1);
		repeat (count)
			append_code_point(random_code_point());
		pos = $urandom_range(text_bytes.size() - 1);
		if (pick < 14) begin
			if ($urandom_range(1))
				text_bytes[pos] = 8'($urandom_range(255));
			else
				text_bytes[pos] = 8'($urandom_range(8'hBF, 8'h80));
		end else if (pick < 20) begin
			if (text_bytes.size() > 1)
				void'(text_bytes.pop_back());
		end else if (pick < 24) begin
			text_bytes.insert(pos, 8'($urandom_range(255)));
		end
	endtask

	task automatic send_text();
		for (int i = 0; i < text_bytes.size(); i++)
			send_byte(text_bytes[i], i == text_bytes.size() - 1, ROW_PREDICT, '0);
	endtask

	// Receiver: random stalls at the phase's rate. A hold-off request makes it refuse
	// every unit for a long, counted stretch while the sender keeps pushing bytes.
	initial begin : unit_receiver
		int hold_left;

		hold_left = 0;
		unit_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HoldCycles;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				unit_ch.ready <= 1'b0;
			end else begin
				unit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Every unit taken from the block is matched against the oldest one owed.
	always @(posedge clk) begin : check_units
		result_t want;

		if (arst_n && unit_ch.valid && unit_ch.ready) begin
			if (pending_units.size() == 0) begin
				$error("unexpected code unit: code_unit %h, error %b, last %b",
					unit_ch.code_unit, unit_ch.error, unit_ch.last);
				error_count++;
			end else begin
				want = pending_units.pop_front();
				if (unit_ch.code_unit !== want.code_unit) begin
					$error("code_unit: expected %h, actual %h", want.code_unit,
						unit_ch.code_unit);
					error_count++;
				end
				if (unit_ch.error !== want.error) begin
					$error("error: expected %b, actual %b", want.error, unit_ch.error);
					error_count++;
				end
				if (unit_ch.last !== want.last) begin
					$error("last: expected %b, actual %b", want.last, unit_ch.last);
					error_count++;
				end
			end
		end
	end

	// Watchdog: the run is stuck if neither channel moves a request for too long.
	always @(posedge clk) begin : watchdog
		int quiet_cycles;

		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("utf8_to_utf16_decoder_test: done, errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase_start;

		error_count = 0;
		live_bytes = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b0;
		clear_decoder();
		arst_n = 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.byte_value <= '0;
		byte_ch.last_byte <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings, free flowing on both sides.
		foreach (DirectedRows[i])
			send_byte(DirectedRows[i].value, DirectedRows[i].fin, DirectedRows[i].kind,
				'{code_unit: DirectedRows[i].code_unit, error: DirectedRows[i].error,
					last: DirectedRows[i].last});
		pause_until_drained();

		// Random strings, one idling pattern per phase. The first phase opens with the
		// long receiver hold-off, so the result queue fills and the byte channel stalls.
		// Each phase ends with the sender waiting for every owed unit.
		for (int phase = 0; phase < PhaseCount; phase++) begin
			send_idle_pct = SendIdlePct[phase];
			recv_stall_pct = RecvStallPct[phase];
			if (phase == 0)
				hold_request = 1'b1;
			phase_start = live_bytes;
			while (live_bytes - phase_start < PhaseBytes) begin
				build_text();
				send_text();
			end
			pause_until_drained();
		end

		// Anything the block still sends now has no unit owed and is flagged.
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0)
			$display("utf8_to_utf16_decoder_test: done, clean");
		else
			$display("utf8_to_utf16_decoder_test: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
src/utd_pkg.sv
src/utd_if.sv
src/utd_decode.sv
src/utd_res_fifo.sv
src/utf8_to_utf16_decoder.sv
src/utd_checker.sv
sim/utf8_to_utf16_decoder_test.sv
